/* rtl/mcst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcst_pkg
// shared types and codes for the soft timer table
// ----------------------------------------------------------------------------
package mcst_pkg;

  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int DL_W    = 33;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 6;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_FIRE      = 3'd3,
    KIND_DONE      = 3'd4,
    KIND_CLEARED   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_CANCEL,
    OP_SEARCH
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LAUNCH,
    ST_PASS,
    ST_RES
  } state_t;

  // token that walks the chain, one cell per cycle
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              rep;
  } tok_t;

  // controls broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic              due_eval;
    logic              fire;
    logic              clear;
    logic [SLOT_W-1:0] fire_slot;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ival;
    logic              per;
    logic [ID_W-1:0]   new_id;
    logic [ID_W-1:0]   target;
  } bcast_t;

endpackage
`default_nettype wire

/* rtl/mcst_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcst_cell
// one timer slot; updates itself as the token passes and forwards it
// ----------------------------------------------------------------------------
module mcst_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mcst_pkg::bcast_t bc,
  input  wire mcst_pkg::tok_t   tok_i,
  output mcst_pkg::tok_t        tok_o
);
  import mcst_pkg::*;

  logic [ID_W-1:0]   ident;
  logic [TIME_W-1:0] period;
  logic [DL_W-1:0]   deadline;
  logic              repeat_q;
  logic              live;
  logic              due;

  logic              live_next;
  logic              due_next;
  logic              wr;
  logic              my_fire;
  tok_t              tok_next;

  assign my_fire = bc.fire && (bc.fire_slot == SLOT_W'(CELL_IDX));

  always_comb begin
    tok_next  = tok_i;
    live_next = live;
    due_next  = due;
    wr        = 1'b0;
    if (tok_i.vld) begin
      case (bc.op)
        OP_ADD: begin
          if (!tok_i.hit && !live) begin
            live_next    = 1'b1;
            tok_next.hit = 1'b1;
            wr           = 1'b1;
          end
        end
        OP_CANCEL: begin
          if (!tok_i.hit && live && (ident == bc.target)) begin
            live_next    = 1'b0;
            tok_next.hit = 1'b1;
          end
        end
        OP_SEARCH: begin
          // strict compare keeps the lowest slot on equal ids
          if (due && (!tok_i.hit || (ident < tok_i.id))) begin
            tok_next.hit  = 1'b1;
            tok_next.id   = ident;
            tok_next.slot = SLOT_W'(CELL_IDX);
            tok_next.rep  = repeat_q;
          end
        end
        default: ;
      endcase
    end
    if (bc.due_eval) begin
      due_next = live && ({1'b0, bc.now} >= deadline);
    end
    if (my_fire) begin
      due_next = 1'b0;
      if (!repeat_q) begin
        live_next = 1'b0;
      end
    end
    if (bc.clear) begin
      live_next = 1'b0;
      due_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= 1'b0;
      due       <= 1'b0;
      tok_o.vld <= 1'b0;
    end else begin
      live  <= live_next;
      due   <= due_next;
      tok_o <= tok_next;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (wr) begin
      ident    <= bc.new_id;
      period   <= bc.ival;
      deadline <= {1'b0, bc.now} + {1'b0, bc.ival};
      repeat_q <= bc.per;
    end else if (my_fire && repeat_q) begin
      deadline <= {1'b0, bc.now} + {1'b0, period};
    end
  end

endmodule
`default_nettype wire

/* rtl/multi_channel_soft_timer_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_table_core
// table of software timers built as a chain of slot cells
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one command word: add, cancel,
//   tick or clear. output channel (out_valid / out_stall) carries result words;
//   every command ends with a word that has last set.
//   add and cancel send one token down the chain of MAX_TIMERS cells; the
//   first free (add) or matching (cancel) cell takes it.
//   tick first latches the due flag in every cell, then runs one chain pass
//   per fired timer: the token picks the lowest id among due cells. a last
//   pass that finds no due cell gives the done word.
//   clear drops every live flag at once.
//   a chain pass moves the token one cell per cycle.
//   in_stall is high while a command is in work; an output stall holds the
//   result register and the fsm; the next result waits until it is taken.
//   reset empties the table, sets the next id to one and drops out_valid.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_table_core #(
  parameter int MAX_TIMERS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] now_time,
  input  wire logic [31:0] interval,
  input  wire logic        periodic,
  input  wire logic [31:0] target_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [31:0]      event_id,
  output logic [5:0]       fired_count,
  output logic [5:0]       live_count,
  output logic             last
);
  import mcst_pkg::*;

  state_t            state;
  state_t            state_next;
  cmd_t              cmd_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] ival_q;
  logic              per_q;
  logic [ID_W-1:0]   target_q;
  logic [ID_W-1:0]   next_ident;
  logic [ID_W-1:0]   next_ident_next;
  logic [CNT_W-1:0]  live_cnt;
  logic [CNT_W-1:0]  fired_cnt;
  tok_t              res_tok;

  kind_t             kind_next;
  logic [ID_W-1:0]   event_id_next;
  logic [CNT_W-1:0]  fired_count_next;
  logic [CNT_W-1:0]  live_count_next;
  logic              last_next;

  tok_t              tok_link [0:MAX_TIMERS];
  bcast_t            bc;
  logic              in_acc;
  logic              out_free;
  logic              launch;
  logic              res_load;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // token injected at the head of the chain
  always_comb begin
    tok_link[0]     = '0;
    tok_link[0].vld = launch;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_TIMERS; g++) begin : g_cell
      mcst_cell #(.CELL_IDX(g)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .bc    (bc),
        .tok_i (tok_link[g]),
        .tok_o (tok_link[g+1])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc) state_next = ST_START;
      ST_START: begin
        if (cmd_q == CMD_CLEAR) state_next = ST_RES;
        else if (cmd_q == CMD_TICK) state_next = ST_LAUNCH;
        else state_next = ST_PASS;
      end
      ST_LAUNCH: state_next = ST_PASS;
      ST_PASS:   if (tok_link[MAX_TIMERS].vld) state_next = ST_RES;
      ST_RES: begin
        if (out_free) begin
          if (cmd_q == CMD_TICK && res_tok.hit) state_next = ST_LAUNCH;
          else state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    in_stall     = (state != ST_IDLE);
    launch       = (state == ST_LAUNCH) ||
                   (state == ST_START && (cmd_q == CMD_ADD || cmd_q == CMD_CANCEL));
    res_load     = (state == ST_RES) && out_free;
    bc           = '0;
    case (cmd_q)
      CMD_ADD:    bc.op = OP_ADD;
      CMD_CANCEL: bc.op = OP_CANCEL;
      CMD_TICK:   bc.op = OP_SEARCH;
      default:    bc.op = OP_NONE;
    endcase
    bc.due_eval  = (state == ST_START) && (cmd_q == CMD_TICK);
    bc.clear     = (state == ST_START) && (cmd_q == CMD_CLEAR);
    bc.fire      = res_load && (cmd_q == CMD_TICK) && res_tok.hit;
    bc.fire_slot = res_tok.slot;
    bc.now       = now_q;
    bc.ival      = ival_q;
    bc.per       = per_q;
    bc.new_id    = next_ident;
    bc.target    = target_q;
  end

  // id counter skips zero on wrap
  always_comb begin
    next_ident_next = next_ident + ID_W'(1);
    if (next_ident_next == '0) begin
      next_ident_next = ID_W'(1);
    end
  end

  // result word for the current pass
  always_comb begin
    kind_next        = KIND_CLEARED;
    event_id_next    = '0;
    fired_count_next = '0;
    live_count_next  = '0;
    last_next        = 1'b1;
    case (cmd_q)
      CMD_ADD: begin
        if (res_tok.hit) begin
          kind_next       = KIND_ADDED;
          event_id_next   = next_ident;
          live_count_next = live_cnt + CNT_W'(1);
        end else begin
          kind_next       = KIND_FULL;
          live_count_next = live_cnt;
        end
      end
      CMD_CANCEL: begin
        kind_next       = KIND_CANCELLED;
        live_count_next = live_cnt - CNT_W'(res_tok.hit);
      end
      CMD_TICK: begin
        if (res_tok.hit) begin
          kind_next       = KIND_FIRE;
          event_id_next   = res_tok.id;
          live_count_next = live_cnt - CNT_W'(!res_tok.rep);
          last_next       = 1'b0;
        end else begin
          kind_next        = KIND_DONE;
          fired_count_next = fired_cnt;
          live_count_next  = live_cnt;
        end
      end
      default: begin
        kind_next       = KIND_CLEARED;
        live_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      next_ident <= ID_W'(1);
      live_cnt   <= '0;
      fired_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fired_cnt <= '0;
      end
      if (res_load) begin
        out_valid <= 1'b1;
        case (cmd_q)
          CMD_ADD: begin
            if (res_tok.hit) begin
              next_ident <= next_ident_next;
              live_cnt   <= live_cnt + CNT_W'(1);
            end
          end
          CMD_CANCEL: if (res_tok.hit) live_cnt <= live_cnt - CNT_W'(1);
          CMD_TICK: begin
            if (res_tok.hit) begin
              fired_cnt <= fired_cnt + CNT_W'(1);
              if (!res_tok.rep) live_cnt <= live_cnt - CNT_W'(1);
            end
          end
          CMD_CLEAR: live_cnt <= '0;
          default: ;
        endcase
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q    <= cmd_t'(cmd);
      now_q    <= now_time;
      ival_q   <= interval;
      per_q    <= periodic;
      target_q <= target_id;
    end
    if (state == ST_PASS && tok_link[MAX_TIMERS].vld) begin
      res_tok <= tok_link[MAX_TIMERS];
    end
    if (res_load) begin
      kind        <= kind_next;
      event_id    <= event_id_next;
      fired_count <= fired_count_next;
      live_count  <= live_count_next;
      last        <= last_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/mcst_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcst_checker
// port level checks on the result channel of the timer table
// ----------------------------------------------------------------------------
module mcst_checker #(
  parameter int MAX_TIMERS = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  kind,
  input wire logic [31:0] event_id,
  input wire logic [5:0]  fired_count,
  input wire logic [5:0]  live_count,
  input wire logic        last
);
  import mcst_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(event_id)
      && $stable(live_count) && $stable(last))
    else $error("result word changed while stalled");

  a_live_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> live_count <= 6'(MAX_TIMERS))
    else $error("live count above table size");

  a_fire_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FIRE |-> !last && event_id != '0)
    else $error("fire word marked last or with zero id");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CLEARED |-> live_count == '0 && last)
    else $error("clear left live timers");

  a_fired: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DONE |-> fired_count == '0)
    else $error("fired count outside tick done");

endmodule

bind multi_channel_soft_timer_table_core mcst_checker #(.MAX_TIMERS(MAX_TIMERS)) u_mcst_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .event_id    (event_id),
  .fired_count (fired_count),
  .live_count  (live_count),
  .last        (last)
);
`default_nettype wire
